// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/ctfl_pkg.sv
// ----------------------------------------------------------------------------
// ctfl_pkg
// Types, codes and defaults of the color transfer function lookup.
// ----------------------------------------------------------------------------
package ctfl_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 1;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_ERASE  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ENABLE = 1'b1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] key_value;
		logic [15:0]        in_red;
		logic [15:0]        in_green;
		logic [15:0]        in_blue;
		logic [15:0]        in_alpha;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [15:0] out_alpha;
		logic [1:0]  status;
		logic [4:0]  point_count;
	} out_item_t;

	typedef struct packed {
		logic signed [15:0] key;
		logic [63:0]        color;
	} entry_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_CLEAR, OP_SCAN_RD, OP_SCAN_LO, OP_SCAN_UP,
		OP_PICK_FIRST, OP_PICK_LAST, OP_PICK_NEAR, OP_OVERWRITE, OP_FULL,
		OP_INS_START, OP_SHIFT_RD, OP_SHIFT_WR, OP_INS_WR,
		OP_ERA_START, OP_ERA_RD, OP_ERA_WR, OP_ERA_DONE,
		OP_MUL_START, OP_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_STORE, OP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SCAN_RD, ST_SCAN_CHK, ST_SCAN_END,
		ST_SHIFT_RD, ST_SHIFT_WR, ST_ERA_RD, ST_ERA_WR,
		ST_MUL, ST_DIV_INIT, ST_DIV, ST_STORE, ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       count_zero;
		logic       full;
		logic       idx_zero;
		logic       idx_at_end;
		logic       rd_gt;
		logic       match;
		logic       nearest;
		logic       ptr_at_idx;
		logic       ptr_at_end;
		logic       step_last;
		logic       ch_last;
		logic       out_free;
	} dp_stat_t;

endpackage

// File: rtl/core/color_transfer_function_lookup_top.sv
// ----------------------------------------------------------------------------
// color_transfer_function_lookup_top
// Sorted control point table with piecewise-linear or nearest color lookup.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Lookup, insert and erase first scan the
// table one point at a time (single-port table memory with registered read;
// a lookup on an empty table skips the scan), then insert and erase shift
// the entries behind the found point one entry at a time. A linear lookup
// between two points works one channel at a time through a multiply stage
// and a 16-step bit-serial divider. Each command gives one result; the result
// register lets the next item be taken while the previous result waits.
module color_transfer_function_lookup_top #(
	parameter int MAX_POINTS = ctfl_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ctfl_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ctfl_pkg::out_item_t             out_item,
	input  logic                            cfg_we,
	input  logic [ctfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctfl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ctfl_pkg::*;

`include "assert_macros.svh"

	dp_op_t   op;
	dp_stat_t stat;

	ctfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_cmd   (in_item.cmd),
		.stat     (stat),
		.op       (op)
	);

	ctfl_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.stat      (stat),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	`ASSERT_IMPLIES(a_out_slot_free, op == OP_OUT, stat.out_free)
	`ASSERT_IMPLIES(a_insert_room, op == OP_INS_WR, !stat.full)

endmodule

// File: rtl/core/ctfl_datapath.sv
// ----------------------------------------------------------------------------
// ctfl_datapath
// Point table memory, scan registers, bit-serial divider and result register.
// ----------------------------------------------------------------------------
module ctfl_datapath #(
	parameter int MAX_POINTS = ctfl_pkg::MAX_POINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ctfl_pkg::dp_op_t                op,
	output ctfl_pkg::dp_stat_t              stat,
	input  ctfl_pkg::in_item_t              in_item,
	input  logic                            cfg_we,
	input  logic [ctfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctfl_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ctfl_pkg::out_item_t             out_item
);
	import ctfl_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	entry_t             mem [MAX_POINTS];
	entry_t             rd_q;
	logic [1:0]         cmd_q;
	logic signed [15:0] key_q;
	logic [63:0]        in_color_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [15:0] lo_key_q;
	logic signed [15:0] up_key_q;
	logic [63:0]        lo_color_q;
	logic [63:0]        up_color_q;
	logic [63:0]        res_color_q;
	logic [1:0]         status_q;
	logic [31:0]        prod_a_q;
	logic [31:0]        prod_b_q;
	logic [15:0]        rem_q;
	logic [15:0]        num_lo_q;
	logic [15:0]        quo_q;
	logic [3:0]         step_q;
	logic [1:0]         ch_q;
	logic               interp_q;
	logic               clamp_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [16:0] dp_w;
	logic signed [16:0] dn_w;
	logic signed [16:0] dd_w;
	logic [15:0]        dp;
	logic [15:0]        dn;
	logic [15:0]        dd;
	logic [31:0]        num;
	logic [16:0]        trial;
	logic [16:0]        trial_sub;
	logic [CNT_W-1:0]   idx_m1;
	logic [CNT_W-1:0]   ptr_m1;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic [IDX_W-1:0]   rd_addr;

	assign dp_w      = 17'(key_q) - 17'(lo_key_q);
	assign dn_w      = 17'(up_key_q) - 17'(key_q);
	assign dd_w      = 17'(up_key_q) - 17'(lo_key_q);
	assign dp        = dp_w[15:0];
	assign dn        = dn_w[15:0];
	assign dd        = dd_w[15:0];
	assign num       = prod_a_q + prod_b_q;
	assign trial     = {rem_q, num_lo_q[15]};
	assign trial_sub = trial - {1'b0, dd};
	assign idx_m1    = idx_q - CNT_W'(1);
	assign ptr_m1    = ptr_q - CNT_W'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_q;
		rd_addr = idx_q[IDX_W-1:0];
		case (op)
			OP_OVERWRITE: begin
				wr_en   = 1'b1;
				wr_addr = idx_m1[IDX_W-1:0];
				wr_data = '{key: key_q, color: in_color_q};
			end
			OP_INS_WR: begin
				wr_en   = 1'b1;
				wr_data = '{key: key_q, color: in_color_q};
			end
			OP_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[IDX_W-1:0];
			end
			OP_ERA_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_m1[IDX_W-1:0];
			end
			OP_SHIFT_RD: rd_addr = ptr_m1[IDX_W-1:0];
			OP_ERA_RD:   rd_addr = ptr_q[IDX_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (op == OP_SCAN_RD || op == OP_SHIFT_RD || op == OP_ERA_RD) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			interp_q    <= 1'b0;
			clamp_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_INTERP_MODE) begin
				interp_q <= cfg_data[0];
			end
			if (cfg_we && cfg_index == CFG_CLAMP_ENABLE) begin
				clamp_q <= cfg_data[0];
			end
			case (op)
				OP_CLEAR:    count_q <= '0;
				OP_INS_WR:   count_q <= count_q + CNT_W'(1);
				OP_ERA_DONE: count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
			if (op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q       <= in_item.cmd;
				key_q       <= in_item.key_value;
				in_color_q  <= {in_item.in_alpha, in_item.in_blue,
				               in_item.in_green, in_item.in_red};
				idx_q       <= '0;
				res_color_q <= '0;
				status_q    <= (in_item.cmd == CMD_LOOKUP && count_q == '0) ?
				               STATUS_EMPTY : STATUS_OK;
			end
			OP_SCAN_LO: begin
				lo_key_q   <= rd_q.key;
				lo_color_q <= rd_q.color;
				idx_q      <= idx_q + CNT_W'(1);
			end
			OP_SCAN_UP: begin
				up_key_q   <= rd_q.key;
				up_color_q <= rd_q.color;
			end
			OP_PICK_FIRST: res_color_q <= clamp_q ? '0 : up_color_q;
			OP_PICK_LAST:  res_color_q <= (clamp_q && key_q != lo_key_q) ? '0 : lo_color_q;
			OP_PICK_NEAR:  res_color_q <= (dp < dn) ? lo_color_q : up_color_q;
			OP_FULL:       status_q <= STATUS_FULL;
			OP_INS_START:  ptr_q <= count_q;
			OP_SHIFT_WR:   ptr_q <= ptr_m1;
			OP_ERA_START:  ptr_q <= idx_q;
			OP_ERA_WR:     ptr_q <= ptr_q + CNT_W'(1);
			OP_MUL_START:  ch_q <= 2'd0;
			OP_MUL: begin
				prod_a_q <= dn * lo_color_q[ch_q*16 +: 16];
				prod_b_q <= dp * up_color_q[ch_q*16 +: 16];
			end
			OP_DIV_INIT: begin
				rem_q    <= num[31:16];
				num_lo_q <= num[15:0];
				step_q   <= '0;
			end
			OP_DIV_STEP: begin
				if (trial >= {1'b0, dd}) begin
					rem_q <= trial_sub[15:0];
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= trial[15:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				num_lo_q <= {num_lo_q[14:0], 1'b0};
				step_q   <= step_q + 4'd1;
			end
			OP_DIV_STORE: begin
				res_color_q[ch_q*16 +: 16] <= quo_q;
				ch_q                       <= ch_q + 2'd1;
			end
			OP_OUT: begin
				out_q.out_red     <= res_color_q[15:0];
				out_q.out_green   <= res_color_q[31:16];
				out_q.out_blue    <= res_color_q[47:32];
				out_q.out_alpha   <= res_color_q[63:48];
				out_q.status      <= status_q;
				out_q.point_count <= 5'(count_q);
			end
			default: ;
		endcase
	end

	assign stat.cmd        = cmd_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.full       = (count_q == CNT_W'(MAX_POINTS));
	assign stat.idx_zero   = (idx_q == '0);
	assign stat.idx_at_end = (idx_q == count_q);
	assign stat.rd_gt      = (rd_q.key > key_q);
	assign stat.match      = (idx_q != '0) && (lo_key_q == key_q);
	assign stat.nearest    = interp_q;
	assign stat.ptr_at_idx = (ptr_q == idx_q);
	assign stat.ptr_at_end = (ptr_q == count_q);
	assign stat.step_last  = (step_q == 4'd15);
	assign stat.ch_last    = (ch_q == 2'd3);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: rtl/core/ctfl_ctrl.sv
// ----------------------------------------------------------------------------
// ctfl_ctrl
// Command sequencer: scan, shift, interpolate and hand off one item at a time.
// ----------------------------------------------------------------------------
module ctfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_cmd,
	input  ctfl_pkg::dp_stat_t stat,
	output ctfl_pkg::dp_op_t   op
);
	import ctfl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_CLEAR) begin
						state_nx = ST_CLEAR;
					end else if (in_cmd == CMD_LOOKUP && stat.count_zero) begin
						state_nx = ST_FINISH;
					end else begin
						state_nx = ST_SCAN_RD;
					end
				end
			end
			ST_CLEAR:    state_nx = ST_FINISH;
			ST_SCAN_RD:  state_nx = stat.idx_at_end ? ST_SCAN_END : ST_SCAN_CHK;
			ST_SCAN_CHK: state_nx = stat.rd_gt ? ST_SCAN_END : ST_SCAN_RD;
			ST_SCAN_END: begin
				case (stat.cmd)
					CMD_LOOKUP: begin
						if (stat.idx_zero || stat.idx_at_end || stat.nearest) begin
							state_nx = ST_FINISH;
						end else begin
							state_nx = ST_MUL;
						end
					end
					CMD_INSERT: begin
						if (stat.match || stat.full) begin
							state_nx = ST_FINISH;
						end else begin
							state_nx = ST_SHIFT_RD;
						end
					end
					CMD_ERASE: state_nx = stat.match ? ST_ERA_RD : ST_FINISH;
					default:   state_nx = ST_FINISH;
				endcase
			end
			ST_SHIFT_RD: state_nx = stat.ptr_at_idx ? ST_FINISH : ST_SHIFT_WR;
			ST_SHIFT_WR: state_nx = ST_SHIFT_RD;
			ST_ERA_RD:   state_nx = stat.ptr_at_end ? ST_FINISH : ST_ERA_WR;
			ST_ERA_WR:   state_nx = ST_ERA_RD;
			ST_MUL:      state_nx = ST_DIV_INIT;
			ST_DIV_INIT: state_nx = ST_DIV;
			ST_DIV:      state_nx = stat.step_last ? ST_STORE : ST_DIV;
			ST_STORE:    state_nx = stat.ch_last ? ST_FINISH : ST_MUL;
			ST_FINISH:   state_nx = stat.out_free ? ST_IDLE : ST_FINISH;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = OP_LOAD;
				end
			end
			ST_CLEAR:    op = OP_CLEAR;
			ST_SCAN_RD:  op = stat.idx_at_end ? OP_NONE : OP_SCAN_RD;
			ST_SCAN_CHK: op = stat.rd_gt ? OP_SCAN_UP : OP_SCAN_LO;
			ST_SCAN_END: begin
				case (stat.cmd)
					CMD_LOOKUP: begin
						if (stat.idx_zero) begin
							op = OP_PICK_FIRST;
						end else if (stat.idx_at_end) begin
							op = OP_PICK_LAST;
						end else if (stat.nearest) begin
							op = OP_PICK_NEAR;
						end else begin
							op = OP_MUL_START;
						end
					end
					CMD_INSERT: begin
						if (stat.match) begin
							op = OP_OVERWRITE;
						end else if (stat.full) begin
							op = OP_FULL;
						end else begin
							op = OP_INS_START;
						end
					end
					CMD_ERASE: op = stat.match ? OP_ERA_START : OP_NONE;
					default:   op = OP_NONE;
				endcase
			end
			ST_SHIFT_RD: op = stat.ptr_at_idx ? OP_INS_WR : OP_SHIFT_RD;
			ST_SHIFT_WR: op = OP_SHIFT_WR;
			ST_ERA_RD:   op = stat.ptr_at_end ? OP_ERA_DONE : OP_ERA_RD;
			ST_ERA_WR:   op = OP_ERA_WR;
			ST_MUL:      op = OP_MUL;
			ST_DIV_INIT: op = OP_DIV_INIT;
			ST_DIV:      op = OP_DIV_STEP;
			ST_STORE:    op = OP_DIV_STORE;
			ST_FINISH:   op = stat.out_free ? OP_OUT : OP_NONE;
			default:     op = OP_NONE;
		endcase
	end

endmodule
